// ----- rtl/core/lrc_pkg.sv -----
// Shared types and constants for the LRU record cache.
package lrc_pkg;

    localparam int HASH_WORDS        = 8;
    localparam int WORD_W            = 64;
    localparam int INDEX_W           = 32;
    localparam int STAMP_W           = 64;
    localparam int SLOT_OUT_W        = 6;
    localparam int DEF_CACHE_ENTRIES = 64;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] hash_word_0;
        logic [WORD_W-1:0] hash_word_1;
        logic [WORD_W-1:0] hash_word_2;
        logic [WORD_W-1:0] hash_word_3;
        logic [WORD_W-1:0] hash_word_4;
        logic [WORD_W-1:0] hash_word_5;
        logic [WORD_W-1:0] hash_word_6;
        logic [WORD_W-1:0] hash_word_7;
        logic [INDEX_W-1:0] out_index;
        logic [WORD_W-1:0] record_in;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [WORD_W-1:0]     record_out;
        logic                  evicted;
        logic [SLOT_OUT_W-1:0] slot_used;
    } rsp_t;

    // One cache slot: full key plus its record word.
    typedef struct packed {
        logic [HASH_WORDS-1:0][WORD_W-1:0] hash;
        logic [INDEX_W-1:0]                out_index;
        logic [WORD_W-1:0]                 record;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish_hit;
        logic finish_miss;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic match;
        logic last;
    } ctl_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

endpackage

// ----- rtl/core/lrc_ctrl.sv -----
// Sequencer for the LRU record cache: accept, scan, then finish on hit or miss.
module lrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lrc_pkg::ctl_sts_t sts,
    output lrc_pkg::ctl_cmd_t cmd
);
    import lrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        busy            = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.empty)
                begin
                    state_next = ST_MISS;
                end
                else if (sts.match)
                begin
                    state_next = ST_HIT;
                end
                else if (sts.last)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_HIT:
            begin
                cmd.finish_hit = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_MISS:
            begin
                cmd.finish_miss = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.finish_hit, cmd.finish_miss}))
        else $error("controller issued overlapping commands");

endmodule

// ----- rtl/core/lrc_datapath.sv -----
// Slot memories, scan compare, LRU search and result register of the cache.
module lrc_datapath #(
    parameter int CACHE_ENTRIES = lrc_pkg::DEF_CACHE_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lrc_pkg::req_t     req,
    input  lrc_pkg::ctl_cmd_t cmd,
    output lrc_pkg::ctl_sts_t sts,
    output logic              done,
    output lrc_pkg::rsp_t     rsp
);
    import lrc_pkg::*;

    localparam int ADDR_W = $clog2(CACHE_ENTRIES);
    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

    entry_t            entry_mem [CACHE_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [CACHE_ENTRIES];

    entry_t             entry_q;
    logic [STAMP_W-1:0] stamp_q;

    req_t               item_reg, item_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [FILL_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]  cmp_addr_reg, cmp_addr_next;
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic [ADDR_W-1:0]  min_slot_reg, min_slot_next;
    logic [ADDR_W-1:0]  hit_slot_reg, hit_slot_next;
    logic [WORD_W-1:0]  hit_rec_reg, hit_rec_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic               issue;
    logic               key_eq;
    logic               full;
    logic               ins_wr;
    logic [ADDR_W-1:0]  new_slot;
    logic [STAMP_W-1:0] stamp_new;
    logic               stamp_we;
    logic [ADDR_W-1:0]  stamp_waddr;
    logic [HASH_WORDS-1:0][WORD_W-1:0] item_hash;
    entry_t             entry_wdata;

    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [ADDR_W-1:0] s);
        logic [ADDR_W+SLOT_OUT_W-1:0] ext;
        ext = {{SLOT_OUT_W{1'b0}}, s};
        return ext[SLOT_OUT_W-1:0];
    endfunction

    assign item_hash = {item_reg.hash_word_7, item_reg.hash_word_6, item_reg.hash_word_5,
                        item_reg.hash_word_4, item_reg.hash_word_3, item_reg.hash_word_2,
                        item_reg.hash_word_1, item_reg.hash_word_0};

    assign issue     = cmd.scan && (rd_cnt_reg < fill_reg);
    assign key_eq    = (entry_q.hash == item_hash) && (entry_q.out_index == item_reg.out_index);
    assign full      = (fill_reg == FILL_W'(CACHE_ENTRIES));
    assign ins_wr    = cmd.finish_miss && (item_reg.cmd == CMD_INSERT);
    assign new_slot  = full ? min_slot_reg : fill_reg[ADDR_W-1:0];
    assign stamp_new = clock_reg + STAMP_W'(1);

    assign sts.empty = (fill_reg == '0);
    assign sts.match = cmp_valid_reg && key_eq;
    assign sts.last  = cmp_valid_reg && ((FILL_W'(cmp_addr_reg) + FILL_W'(1)) == fill_reg);

    assign stamp_we    = cmd.finish_hit || ins_wr;
    assign stamp_waddr = cmd.finish_hit ? hit_slot_reg : new_slot;

    always_comb
    begin
        entry_wdata           = '0;
        entry_wdata.hash      = item_hash;
        entry_wdata.out_index = item_reg.out_index;
        entry_wdata.record    = item_reg.record_in;
    end

    // Slot memories: one read port feeding the scan, one write port.
    always_ff @(posedge clk)
    begin
        entry_q <= entry_mem[rd_cnt_reg[ADDR_W-1:0]];
        stamp_q <= stamp_mem[rd_cnt_reg[ADDR_W-1:0]];
        if (ins_wr)
        begin
            entry_mem[new_slot] <= entry_wdata;
        end
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_new;
        end
    end

    always_comb
    begin
        item_next      = cmd.load ? req : item_reg;
        rd_cnt_next    = rd_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_addr_next  = rd_cnt_reg[ADDR_W-1:0];
        if (cmd.load)
        begin
            rd_cnt_next = '0;
        end
        else if (issue)
        begin
            rd_cnt_next    = rd_cnt_reg + FILL_W'(1);
            cmp_valid_next = 1'b1;
        end

        // LRU tracking runs alongside the key compare; first slot seeds it,
        // strict less-than keeps the lowest slot on ties.
        min_stamp_next = min_stamp_reg;
        min_slot_next  = min_slot_reg;
        if (cmp_valid_reg && ((cmp_addr_reg == '0) || (stamp_q < min_stamp_reg)))
        begin
            min_stamp_next = stamp_q;
            min_slot_next  = cmp_addr_reg;
        end

        hit_slot_next = hit_slot_reg;
        hit_rec_next  = hit_rec_reg;
        if (cmd.scan && sts.match)
        begin
            hit_slot_next = cmp_addr_reg;
            hit_rec_next  = entry_q.record;
        end

        fill_next  = fill_reg;
        clock_next = clock_reg;
        if (cmd.finish_hit || ins_wr)
        begin
            clock_next = stamp_new;
        end
        if (ins_wr && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end

        done_next = cmd.finish_hit || cmd.finish_miss;
        rsp_next  = rsp_reg;
        if (cmd.finish_hit)
        begin
            rsp_next.hit        = 1'b1;
            rsp_next.record_out = (item_reg.cmd == CMD_INSERT) ? '0 : hit_rec_reg;
            rsp_next.evicted    = 1'b0;
            rsp_next.slot_used  = slot_out(hit_slot_reg);
        end
        else if (cmd.finish_miss)
        begin
            rsp_next = '0;
            if (item_reg.cmd == CMD_INSERT)
            begin
                rsp_next.evicted   = full;
                rsp_next.slot_used = slot_out(new_slot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            clock_reg     <= '0;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            clock_reg     <= clock_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        cmp_addr_reg  <= cmp_addr_next;
        min_stamp_reg <= min_stamp_next;
        min_slot_reg  <= min_slot_next;
        hit_slot_reg  <= hit_slot_next;
        hit_rec_reg   <= hit_rec_next;
        rsp_reg       <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CACHE_ENTRIES))
        else $error("fill count beyond cache size");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.finish_hit || cmd.finish_miss))
        else $error("result word without a finished access");

    a_clock_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_hit |=> (clock_reg == $past(clock_reg) + STAMP_W'(1)))
        else $error("access clock did not advance on hit");

endmodule

// ----- rtl/core/lru_record_cache.sv -----
// Top level of the fully associative LRU record cache.
//
// Usage:
//   Command side: drive req and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   access has finished.
//   Result side: one result word per command, shown on rsp for exactly one
//   cycle with done high. There is no backpressure; the receiver must take
//   it in that cycle.
// Timing:
//   The block walks the occupied slots one per cycle through the single
//   read port of the slot memories, comparing the key and tracking the
//   lowest stamp in the same pass. A hit ends the walk at the matching slot;
//   a miss walks every occupied slot, and an empty cache goes straight to
//   a miss. done rises in the same cycle that busy drops,
//   and the next command may be accepted in that same cycle.
// Reset:
//   rst_n clears the fill count, the access clock and the controller; slot
//   contents are never read before being written, so no clearing pass.
module lru_record_cache #(
    parameter int CACHE_ENTRIES = lrc_pkg::DEF_CACHE_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lrc_pkg::req_t req,
    output logic          done,
    output lrc_pkg::rsp_t rsp
);
    import lrc_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    lrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    lrc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for lru_record_cache: key pools, LRU replacement and lookup checks.
module testbench;

    import lrc_pkg::*;

    localparam int CACHE_ENTRIES = DEF_CACHE_ENTRIES;
    localparam int HASH_BITS     = HASH_WORDS * WORD_W;
    localparam int POOL_MAX      = 128;
    localparam int TAIL_CYCLES   = 80;    // covers the longest scan, a miss over a full cache
    localparam int DRAIN_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    lru_record_cache u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Shadow copy of the cache contents
    logic [HASH_BITS-1:0] slot_hash   [0:CACHE_ENTRIES-1];
    logic [INDEX_W-1:0]   slot_index  [0:CACHE_ENTRIES-1];
    logic [WORD_W-1:0]    slot_record [0:CACHE_ENTRIES-1];
    logic [STAMP_W-1:0]   slot_stamp  [0:CACHE_ENTRIES-1];
    int                   slots_filled;
    logic [STAMP_W-1:0]   access_count;

    rsp_t pending_rsp [$];

    // Keys that random traffic keeps coming back to
    logic [HASH_BITS-1:0] key_pool [0:POOL_MAX-1];
    logic [INDEX_W-1:0]   idx_pool [0:POOL_MAX-1];
    int                   pool_size;

    int errors;
    int results_seen;
    int n_lookup;
    int n_insert;
    int n_hit;
    int n_evict;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic rsp_t cache_access(input req_t w);
        logic [HASH_BITS-1:0] key;
        rsp_t r;
        int   slot;
        bit   found;
        key = {w.hash_word_7, w.hash_word_6, w.hash_word_5, w.hash_word_4,
               w.hash_word_3, w.hash_word_2, w.hash_word_1, w.hash_word_0};
        r     = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < slots_filled; i++)
        begin
            if (!found && slot_hash[i] == key && slot_index[i] == w.out_index)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            access_count     = access_count + 1;
            slot_stamp[slot] = access_count;
            r.hit            = 1'b1;
            r.record_out     = (w.cmd == CMD_INSERT) ? '0 : slot_record[slot];
            r.slot_used      = slot[SLOT_OUT_W-1:0];
        end
        else if (w.cmd == CMD_INSERT)
        begin
            if (slots_filled < CACHE_ENTRIES)
            begin
                slot         = slots_filled;
                slots_filled = slots_filled + 1;
            end
            else
            begin
                // strict less-than: lowest slot wins on equal stamps
                for (int i = 1; i < CACHE_ENTRIES; i++)
                    if (slot_stamp[i] < slot_stamp[slot])
                        slot = i;
                r.evicted = 1'b1;
            end
            slot_hash[slot]   = key;
            slot_index[slot]  = w.out_index;
            slot_record[slot] = w.record_in;
            access_count      = access_count + 1;
            slot_stamp[slot]  = access_count;
            r.slot_used       = slot[SLOT_OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic req_t pack_word(input logic c, input logic [HASH_BITS-1:0] k,
                                       input logic [INDEX_W-1:0] ix,
                                       input logic [WORD_W-1:0] rec);
        req_t w;
        w.cmd         = c;
        w.hash_word_0 = k[0*WORD_W +: WORD_W];
        w.hash_word_1 = k[1*WORD_W +: WORD_W];
        w.hash_word_2 = k[2*WORD_W +: WORD_W];
        w.hash_word_3 = k[3*WORD_W +: WORD_W];
        w.hash_word_4 = k[4*WORD_W +: WORD_W];
        w.hash_word_5 = k[5*WORD_W +: WORD_W];
        w.hash_word_6 = k[6*WORD_W +: WORD_W];
        w.hash_word_7 = k[7*WORD_W +: WORD_W];
        w.out_index   = ix;
        w.record_in   = rec;
        return w;
    endfunction

    function automatic logic [HASH_BITS-1:0] rand_key();
        logic [HASH_BITS-1:0] k;
        for (int i = 0; i < HASH_BITS / 32; i++)
            k[i*32 +: 32] = $urandom;
        return k;
    endfunction

    // Some pool keys differ from their neighbor in one hash word only (the index
    // may differ too), so each word comparator has to do the work on its own.
    task automatic refill_pool(input int n, input int share_pct);
        int wsel;
        pool_size = n;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < share_pct)
            begin
                wsel        = $urandom_range(0, HASH_WORDS - 1);
                key_pool[i] = key_pool[i-1];
                key_pool[i][wsel*WORD_W +: WORD_W] = {$urandom, $urandom};
                idx_pool[i] = ($urandom_range(0, 1) == 0) ? idx_pool[i-1] : $urandom;
            end
            else
            begin
                key_pool[i] = rand_key();
                idx_pool[i] = $urandom;
            end
        end
    endtask

    function automatic req_t random_word(input int ins_pct, input int fresh_pct,
                                         input int near_pct);
        logic [HASH_BITS-1:0] k;
        logic [INDEX_W-1:0]   ix;
        logic [WORD_W-1:0]    rec;
        int                   sel;
        int                   p;
        int                   b;
        sel = $urandom_range(0, 99);
        p   = $urandom_range(0, pool_size - 1);
        k   = key_pool[p];
        ix  = idx_pool[p];
        if (sel < fresh_pct)
        begin
            k  = rand_key();
            ix = $urandom;
        end
        else if (sel < fresh_pct + near_pct)
        begin
            // one flipped bit anywhere in the key
            b = $urandom_range(0, HASH_BITS + INDEX_W - 1);
            if (b < HASH_BITS)
                k[b] = ~k[b];
            else
                ix[b - HASH_BITS] = ~ix[b - HASH_BITS];
        end
        case ($urandom_range(0, 15))
            0:       rec = '0;
            1:       rec = '1;
            default: rec = {$urandom, $urandom};
        endcase
        return pack_word(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_LOOKUP,
                         k, ix, rec);
    endfunction

    // start stays high after the word is taken; callers lower it by
    // hold_off or wait_for_results, so back-to-back words need no toggle.
    task automatic send_word(input req_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(cache_access(w));
        if (w.cmd == CMD_INSERT)
            n_insert++;
        else
            n_lookup++;
        if (pending_rsp[$].hit)
            n_hit++;
        if (pending_rsp[$].evicted)
            n_evict++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        int spin;
        start <= 1'b0;
        spin = 0;
        while (pending_rsp.size() != 0 && spin < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n, input int ins_pct, input int fresh_pct,
                              input int near_pct, input bit idle);
        bit quiet;
        quiet = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (idle && !quiet && $urandom_range(0, 4) == 0)
                hold_off($urandom_range(1, 18));
            send_word(random_word(ins_pct, fresh_pct, near_pct));
        end
    endtask

    task automatic log_mismatch(input string what, input logic [WORD_W-1:0] want_v,
                                input logic [WORD_W-1:0] got_v);
        errors++;
        if (errors <= REPORT_MAX)
            $display("mismatch at %0t: %s expected 0x%0h got 0x%0h",
                     $realtime, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
                log_mismatch("result word with none pending, slot", '0,
                             WORD_W'(rsp.slot_used));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.hit !== want.hit)
                    log_mismatch("hit", WORD_W'(want.hit), WORD_W'(rsp.hit));
                if (rsp.record_out !== want.record_out)
                    log_mismatch("record_out", want.record_out, rsp.record_out);
                if (rsp.evicted !== want.evicted)
                    log_mismatch("evicted", WORD_W'(want.evicted), WORD_W'(rsp.evicted));
                if (rsp.slot_used !== want.slot_used)
                    log_mismatch("slot_used", WORD_W'(want.slot_used),
                                 WORD_W'(rsp.slot_used));
            end
        end
    end

    // Extreme keys, refresh of a present key, and keys off by one word or the index
    task automatic test_directed_keys();
        logic [HASH_BITS-1:0] ones;
        logic [HASH_BITS-1:0] near;
        ones = '1;
        send_word(pack_word(CMD_LOOKUP, '0, '0, '1));       // miss on empty cache
        send_word(pack_word(CMD_INSERT, '0, '0, '0));
        send_word(pack_word(CMD_LOOKUP, '0, '0, '1));
        send_word(pack_word(CMD_INSERT, ones, '1, '1));
        send_word(pack_word(CMD_LOOKUP, ones, '1, '0));
        send_word(pack_word(CMD_INSERT, ones, '1, '0));     // refresh only, record kept
        send_word(pack_word(CMD_LOOKUP, ones, '1, '0));
        send_word(pack_word(CMD_LOOKUP, ones, '0, '0));
        for (int k = 0; k < HASH_WORDS; k++)
        begin
            near = ones;
            near[k*WORD_W +: WORD_W] = '0;
            send_word(pack_word(CMD_LOOKUP, near, '1, '0));
        end
        send_word(pack_word(CMD_INSERT, ones, '0, 64'h5a5a_0f0f_3c3c_a5a5));
        send_word(pack_word(CMD_LOOKUP, ones, '0, '0));
        send_word(pack_word(CMD_LOOKUP, '0, '1, '0));
        send_word(pack_word(CMD_INSERT, '0, '0, '1));
        wait_for_results();
    endtask

    // Working set smaller than the cache: mostly hits
    task automatic test_hit_heavy();
        refill_pool(40, 25);
        run_random(300, 35, 4, 6, 1'b1);
        wait_for_results();
    endtask

    // Working set larger than the cache: steady LRU replacement
    task automatic test_lru_eviction();
        refill_pool(100, 20);
        run_random(250, 65, 5, 5, 1'b1);
        wait_for_results();
        refill_pool(CACHE_ENTRIES + 1, 10);
        run_random(250, 55, 3, 5, 1'b1);
        wait_for_results();
    endtask

    // Fresh and near-miss keys dominate
    task automatic test_key_noise();
        refill_pool(30, 50);
        run_random(250, 50, 25, 30, 1'b1);
        wait_for_results();
    endtask

    // Closing stretch with start held high between words
    task automatic test_back_to_back();
        refill_pool(80, 20);
        run_random(230, 50, 5, 10, 1'b0);
        wait_for_results();
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
        n_lookup     = 0;
        n_insert     = 0;
        n_hit        = 0;
        n_evict      = 0;
        slots_filled = 0;
        access_count = '0;
        pool_size    = 1;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keys();
        test_hit_heavy();
        test_lru_eviction();
        test_key_noise();
        test_back_to_back();

        if (pending_rsp.size() != 0)
            log_mismatch("results never delivered, count", '0,
                         WORD_W'(pending_rsp.size()));
        $display("Ran %0d lookups and %0d inserts; %0d result words checked",
                 n_lookup, n_insert, results_seen);
        $display("Traffic gave %0d hits and %0d LRU replacements, %0d mismatches",
                 n_hit, n_evict, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lrc_pkg.sv
rtl/core/lrc_ctrl.sv
rtl/core/lrc_datapath.sv
rtl/core/lru_record_cache.sv
bench/testbench.sv
